>>> rtl/core/odbp_pkg.sv
// Shared types and constants for the ordered dither bitmap packer.
// Holds the Bayer threshold table, register indexes and the work record type.
// No dependencies.
package odbp_pkg;

   localparam int SUM_W = 10;
   localparam int POS_W = 3;
   localparam int ACC_W = 7;
   localparam int BYTE_W = 8;
   localparam int CSR_W = 16;
   localparam int CSR_IDX_W = 1;
   localparam int PIXEL_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [7:0] ALPHA_MIN = 8'h80;

   // (R+G+B)/12 <= t holds exactly when R+G+B < 12*(t+1); entries indexed {col[1:0], row[1:0]}
   localparam logic [SUM_W-1:0] BAYER_LIMIT [16] = '{
      10'd12,  10'd396, 10'd108, 10'd492,
      10'd588, 10'd204, 10'd684, 10'd300,
      10'd156, 10'd540, 10'd60,  10'd444,
      10'd732, 10'd348, 10'd636, 10'd252
   };

   typedef struct packed {
      logic             alpha_ok;
      logic [SUM_W-1:0] sum;
      logic [SUM_W-1:0] limit;
      logic [POS_W-1:0] pos;
      logic             close;
      logic             row_end;
      logic             image_end;
   } odbp_rec_type;

endpackage

>>> rtl/core/odbp_front.sv
// Front end: accepts pixels, tracks column and row, classifies each beat.
// Holds the size registers and pushes one work record per pixel.
// Depends on odbp_pkg.
module odbp_front #(
   parameter int MAX_SIDE = 32768
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      csr_we,
   input  logic [odbp_pkg::CSR_IDX_W-1:0]            csr_index,
   input  logic [odbp_pkg::CSR_W-1:0]                csr_wdata,
   input  logic                                      req_valid,
   output logic                                      req_ready,
   input  logic [odbp_pkg::PIXEL_W-1:0]              req_argb_pixel,
   output logic                                      push,
   output odbp_pkg::odbp_rec_type                    push_rec,
   input  logic                                      q_ready
);
   import odbp_pkg::*;

   localparam int CW = $clog2(MAX_SIDE);
   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam logic [CSR_W:0] MAX_EXT = (CSR_W + 1)'(MAX_SIDE);

   logic [CSR_W-1:0] width_ff, width_in;
   logic [CSR_W-1:0] height_ff, height_in;
   logic [CW-1:0]    col_ff, col_in;
   logic [CW-1:0]    row_ff, row_in;

   logic [CSR_W:0] w_clamp, h_clamp;
   logic [SW-1:0]  w_eff, h_eff;
   logic [SW-1:0]  col_next, row_next;
   logic           row_done, img_done;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata;
            CSR_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == '0) begin
         w_clamp = (CSR_W + 1)'(1);
      end else if ({1'b0, width_ff} > MAX_EXT) begin
         w_clamp = MAX_EXT;
      end else begin
         w_clamp = {1'b0, width_ff};
      end
      if (height_ff == '0) begin
         h_clamp = (CSR_W + 1)'(1);
      end else if ({1'b0, height_ff} > MAX_EXT) begin
         h_clamp = MAX_EXT;
      end else begin
         h_clamp = {1'b0, height_ff};
      end
      w_eff = w_clamp[SW-1:0];
      h_eff = h_clamp[SW-1:0];

      col_next = SW'(col_ff) + SW'(1);
      row_next = SW'(row_ff) + SW'(1);
      row_done = col_next >= w_eff;
      img_done = row_done && (row_next >= h_eff);

      req_ready = q_ready;
      push      = req_valid && q_ready;

      push_rec.alpha_ok  = req_argb_pixel[31:24] >= ALPHA_MIN;
      push_rec.sum       = SUM_W'(req_argb_pixel[23:16]) + SUM_W'(req_argb_pixel[15:8])
                         + SUM_W'(req_argb_pixel[7:0]);
      push_rec.limit     = BAYER_LIMIT[{col_ff[1:0], row_ff[1:0]}];
      push_rec.pos       = col_ff[POS_W-1:0];
      push_rec.close     = (col_ff[POS_W-1:0] == '1) || row_done;
      push_rec.row_end   = row_done;
      push_rec.image_end = img_done;

      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (row_done) begin
            col_in = '0;
            row_in = img_done ? '0 : row_next[CW-1:0];
         end else begin
            col_in = col_next[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_W'(1);
         height_ff <= CSR_W'(1);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

>>> rtl/core/odbp_queue.sv
// Two-entry queue of work records between front and back end.
// Depends on odbp_pkg.
module odbp_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  odbp_pkg::odbp_rec_type push_rec,
   output logic                   q_ready,
   input  logic                   pop,
   output odbp_pkg::odbp_rec_type pop_rec,
   output logic                   q_valid
);
   import odbp_pkg::*;

   localparam int DEPTH = 2;

   odbp_rec_type entry_ff [DEPTH];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;

   always_comb begin
      q_ready   = count_ff != 2'(DEPTH);
      q_valid   = count_ff != '0;
      pop_rec   = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH)) else $error("queue count overflow");
   a_no_empty_pop: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid) else $error("pop from empty queue");
   a_no_full_push: assert property (@(posedge clock) disable iff (reset)
      push |-> q_ready) else $error("push into full queue");
`endif

endmodule

>>> rtl/core/odbp_back.sv
// Back end: thresholds each record, gathers bits and drives the result register.
// Depends on odbp_pkg.
module odbp_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  odbp_pkg::odbp_rec_type      pop_rec,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [odbp_pkg::BYTE_W-1:0] rsp_packed_byte,
   output logic                        rsp_row_end,
   output logic                        rsp_image_end
);
   import odbp_pkg::*;

   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              row_end_ff, row_end_in;
   logic              img_end_ff, img_end_in;
   logic              bit_val;
   logic [BYTE_W-1:0] merged;
   logic              slot_free;

   always_comb begin
      slot_free = !valid_ff || rsp_ready;
      pop       = q_valid && (!pop_rec.close || slot_free);
      bit_val   = pop_rec.alpha_ok && (pop_rec.sum < pop_rec.limit);
      merged    = {1'b0, acc_ff} | (BYTE_W'(bit_val) << pop_rec.pos);

      acc_in     = acc_ff;
      valid_in   = valid_ff && !rsp_ready;
      byte_in    = byte_ff;
      row_end_in = row_end_ff;
      img_end_in = img_end_ff;
      if (pop) begin
         if (pop_rec.close) begin
            acc_in     = '0;
            valid_in   = 1'b1;
            byte_in    = merged;
            row_end_in = pop_rec.row_end;
            img_end_in = pop_rec.image_end;
         end else begin
            acc_in = merged[ACC_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      row_end_ff <= row_end_in;
      img_end_ff <= img_end_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_packed_byte = byte_ff;
   assign rsp_row_end     = row_end_ff;
   assign rsp_image_end   = img_end_ff;

`ifndef SYNTHESIS
   a_image_end_row: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (!img_end_ff || row_end_ff)) else $error("image end without row end");
   a_acc_cleared: assert property (@(posedge clock) disable iff (reset)
      (pop && pop_rec.close) |=> (acc_ff == '0)) else $error("accumulator not cleared");
   a_acc_above_pos: assert property (@(posedge clock) disable iff (reset)
      (q_valid && pop_rec.pos == '0) |-> (acc_ff == '0)) else $error("stale bits at byte start");
`endif

endmodule

>>> rtl/core/ordered_dither_bitmap_packer_top.sv
// Top level of the ordered dither 1bpp packer: front end, queue, back end.
// A closing pixel reaches rsp through a queue entry, then the result register.
// Throughput: 1 pixel per cycle while q_ready; one byte per 8 pixels or per row end.
// The queue (2 entries) lets the front keep taking pixels while a byte waits on rsp.
// Reset (synchronous) clears position, accumulator and queue; sizes return to 1x1.
// Depends on odbp_pkg, odbp_front, odbp_queue, odbp_back.
module ordered_dither_bitmap_packer_top #(
   parameter int MAX_SIDE = 32768
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [odbp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [odbp_pkg::CSR_W-1:0]          csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [odbp_pkg::PIXEL_W-1:0]        req_argb_pixel,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [odbp_pkg::BYTE_W-1:0]         rsp_packed_byte,
   output logic                                rsp_row_end,
   output logic                                rsp_image_end
);
   import odbp_pkg::*;

   logic         push, pop, q_ready, q_valid;
   odbp_rec_type push_rec, pop_rec;

   odbp_front #(.MAX_SIDE(MAX_SIDE)) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_argb_pixel (req_argb_pixel),
      .push           (push),
      .push_rec       (push_rec),
      .q_ready        (q_ready)
   );

   odbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .q_ready  (q_ready),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .q_valid  (q_valid)
   );

   odbp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .pop_rec         (pop_rec),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_packed_byte (rsp_packed_byte),
      .rsp_row_end     (rsp_row_end),
      .rsp_image_end   (rsp_image_end)
   );

endmodule
